### hw/rtl/hpb_pkg.sv
// ----------------------------------------------------------------------------
// hpb_pkg
// Shared widths, latencies, result type and elaboration-time constants for
// the horizontal projection basis core (Q60 CORDIC constants).
// ----------------------------------------------------------------------------
package hpb_pkg;

    // field widths of one beat
    localparam int ALT_W  = 25;
    localparam int AZ_W   = 26;
    localparam int VEC_W  = 32;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 264;

    // default parameter values
    localparam int DEF_ANGLE_FRAC_BITS = 16;
    localparam int DEF_OUT_FRAC_BITS   = 30;
    localparam int DEF_CORDIC_STAGES   = 32;

    // pipeline depth of the angle reduction and the combining stages
    localparam int RED_LAT  = 7;
    localparam int COMB_LAT = 6;

    localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

    // result vectors, Q1.OUT_FRAC_BITS in 32 bits each
    typedef struct packed {
        logic [VEC_W-1:0] up_z;
        logic [VEC_W-1:0] up_y;
        logic [VEC_W-1:0] up_x;
        logic [VEC_W-1:0] right_y;
        logic [VEC_W-1:0] right_x;
        logic [VEC_W-1:0] center_z;
        logic [VEC_W-1:0] center_y;
        logic [VEC_W-1:0] center_x;
    } hpb_vec_t;

    // (a * b) >> 60, kept to 64 bits
    function automatic logic [63:0] mul_q60_f(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // shift-subtract unsigned division for the constant tables
    function automatic logic [63:0] udiv64_f(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = 65'd0;
        q   = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q60 by its series, i >= 1
    function automatic logic [63:0] atan_pow2_f(input int i);
        logic [63:0] sum;
        logic [63:0] p;
        logic [63:0] d;
        logic        neg;
        sum = 64'd0;
        p   = ONE_Q60 >> i;
        neg = 1'b0;
        for (int k = 0; k < 64; k++) begin
            if (p != 64'd0) begin
                d   = 64'(2 * k + 1);
                sum = neg ? sum - udiv64_f(p, d) : sum + udiv64_f(p, d);
                neg = !neg;
                p   = (2 * i < 64) ? p >> (2 * i) : 64'd0;
            end
        end
        return sum;
    endfunction

    // pi/4 = atan(1/2) + atan(1/3)
    function automatic logic [63:0] quarter_pi_f();
        logic [63:0] sum;
        logic [63:0] p;
        logic [63:0] d;
        logic        neg;
        sum = atan_pow2_f(1);
        p   = ONE_Q60 / 64'd3;
        neg = 1'b0;
        for (int k = 0; k < 64; k++) begin
            if (p != 64'd0) begin
                d   = 64'(2 * k + 1);
                sum = neg ? sum - udiv64_f(p, d) : sum + udiv64_f(p, d);
                neg = !neg;
                p   = udiv64_f(p, 64'd9);
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] atan_q60_f(input int i);
        return (i == 0) ? quarter_pi_f() : atan_pow2_f(i);
    endfunction

    // 1/G for n stages: G^2 product, then Newton steps on 1/sqrt
    function automatic logic [63:0] inv_gain_f(input int n);
        logic [63:0] g2;
        logic [63:0] y;
        logic [63:0] t;
        g2 = ONE_Q60;
        for (int i = 0; i < 64; i++) begin
            if (i < n && 2 * i < 64)
                g2 = g2 + (g2 >> (2 * i));
        end
        y = ONE_Q60 / 64'd10 * 64'd6;
        for (int i = 0; i < 8; i++) begin
            t = mul_q60_f(g2, mul_q60_f(y, y));
            y = mul_q60_f(y, 64'd3 * ONE_Q60 - t) >> 1;
        end
        return y;
    endfunction

    localparam logic [63:0] PI_Q60 = 64'd4 * quarter_pi_f();

endpackage

### hw/rtl/hpb_reduce.sv
// ----------------------------------------------------------------------------
// hpb_reduce
// Reduces a fixed-point degree angle modulo one turn, splits it into a
// quadrant and a residual, and converts the residual to Q60 radians.
// ----------------------------------------------------------------------------
module hpb_reduce #(
    parameter int W   = hpb_pkg::AZ_W,
    parameter int AFB = hpb_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic                aclk,
    input  logic                ce,
    input  logic signed [W-1:0] angle_in,
    output logic [1:0]          quad_out,
    output logic [63:0]         z_out
);

    localparam logic [63:0] TURN = 64'd360 << AFB;
    localparam logic [63:0] QTR  = 64'd90 << AFB;
    localparam int RW  = $clog2(TURN);
    localparam int SH  = W + RW;
    localparam logic [63:0] MUL = (64'd1 << SH) / TURN;
    localparam int MW  = $clog2(MUL + 64'd1);
    localparam int QWR = W - RW + 1;
    localparam int QW  = (QWR < 1) ? 1 : QWR;
    localparam int PW  = (W + MW > SH + QW) ? W + MW : SH + QW;
    localparam int TW  = RW + QW;
    localparam logic [63:0] CMOD = (64'd1 << (W - 1)) % TURN;
    localparam int QRW = $clog2(QTR);
    localparam logic [63:0] RPL = (hpb_pkg::PI_Q60 + (64'd90 << AFB)) / (64'd180 << AFB);
    localparam int RPLW  = $clog2(RPL + 64'd1);
    localparam int LOW_W = 24;
    localparam int HIW   = RPLW - LOW_W;
    localparam logic [63:0] RPL_HI = RPL >> LOW_W;

    logic [W-1:0]        au;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [W-1:0]        au1_reg, au2_reg;
    logic [W-1:0]        qt_reg, qt_next;
    logic [W-1:0]        r0;
    logic [RW-1:0]       r1_reg, r1_next;
    logic [RW-1:0]       r2_reg, r2_next;
    logic [1:0]          quad5_reg, quad5_next, quad6_reg, quad7_reg;
    logic [QRW-1:0]      res_reg, res_next;
    logic [QRW+LOW_W-1:0] plo_reg, plo_next;
    logic [QRW+HIW-1:0]  phi_reg, phi_next;
    logic [63:0]         z_reg, z_next;
    logic [63:0]         qbase;

    // offset binary so the reduction works on an unsigned value
    assign au = {~angle_in[W-1], angle_in[W-2:0]};

    always_comb begin
        // quotient estimate, one short of the true one at most
        prod_next = PW'(au) * PW'(MUL);
        qt_next   = W'(TW'(prod_reg[SH +: QW]) * TW'(TURN));
        // one correction, then undo the offset
        r0        = au2_reg - qt_reg;
        r1_next   = (64'(r0) >= TURN) ? RW'(64'(r0) - TURN) : RW'(r0);
        r2_next   = (64'(r1_reg) >= CMOD) ? RW'(64'(r1_reg) - CMOD)
                                          : RW'(64'(r1_reg) + TURN - CMOD);
        // quadrant and residual
        if (64'(r2_reg) >= 64'd3 * QTR) begin
            quad5_next = 2'd3;
            qbase      = 64'd3 * QTR;
        end else if (64'(r2_reg) >= 64'd2 * QTR) begin
            quad5_next = 2'd2;
            qbase      = 64'd2 * QTR;
        end else if (64'(r2_reg) >= QTR) begin
            quad5_next = 2'd1;
            qbase      = QTR;
        end else begin
            quad5_next = 2'd0;
            qbase      = 64'd0;
        end
        res_next = QRW'(64'(r2_reg) - qbase);
        // degrees to Q60 radians in two partial products
        plo_next = (QRW+LOW_W)'(res_reg) * (QRW+LOW_W)'(RPL[LOW_W-1:0]);
        phi_next = (QRW+HIW)'(res_reg) * (QRW+HIW)'(RPL_HI);
        z_next   = (64'(phi_reg) << LOW_W) + 64'(plo_reg);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg  <= prod_next;
            au1_reg   <= au;
            qt_reg    <= qt_next;
            au2_reg   <= au1_reg;
            r1_reg    <= r1_next;
            r2_reg    <= r2_next;
            quad5_reg <= quad5_next;
            res_reg   <= res_next;
            quad6_reg <= quad5_reg;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            quad7_reg <= quad6_reg;
            z_reg     <= z_next;
        end
    end

    assign quad_out = quad7_reg;
    assign z_out    = z_reg;

endmodule

### hw/rtl/hpb_cordic.sv
// ----------------------------------------------------------------------------
// hpb_cordic
// Rotation-mode CORDIC, one register stage per iteration, Q60 datapath,
// then clamp to the unit range and map the quadrant to sine and cosine.
// ----------------------------------------------------------------------------
module hpb_cordic #(
    parameter int STAGES = hpb_pkg::DEF_CORDIC_STAGES
) (
    input  logic               aclk,
    input  logic               ce,
    input  logic [1:0]         quad_in,
    input  logic [63:0]        z_in,
    output logic signed [61:0] sin_out,
    output logic signed [61:0] cos_out
);

    localparam logic signed [63:0] INV_GAIN = hpb_pkg::inv_gain_f(STAGES);
    localparam logic signed [63:0] ONE      = hpb_pkg::ONE_Q60;

    logic signed [63:0] x_reg [1:STAGES];
    logic signed [63:0] y_reg [1:STAGES];
    logic signed [63:0] z_reg [1:STAGES];
    logic [1:0]         q_reg [1:STAGES];
    logic signed [63:0] xc, yc;
    logic signed [63:0] s_next, c_next;
    logic signed [61:0] sin_reg, cos_reg;

    // micro-rotations
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [63:0] ATN = hpb_pkg::atan_q60_f(i);
        logic signed [63:0] xi, yi, zi;
        logic [1:0]         qi;
        if (i == 0) begin : g_first
            assign xi = INV_GAIN;
            assign yi = 64'sd0;
            assign zi = z_in;
            assign qi = quad_in;
        end else begin : g_next
            assign xi = x_reg[i];
            assign yi = y_reg[i];
            assign zi = z_reg[i];
            assign qi = q_reg[i];
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (zi >= 0) begin
                    x_reg[i+1] <= xi - (yi >>> i);
                    y_reg[i+1] <= yi + (xi >>> i);
                    z_reg[i+1] <= zi - ATN;
                end else begin
                    x_reg[i+1] <= xi + (yi >>> i);
                    y_reg[i+1] <= yi - (xi >>> i);
                    z_reg[i+1] <= zi + ATN;
                end
                q_reg[i+1] <= qi;
            end
        end
    end

    // clamp and quadrant map
    always_comb begin
        xc = (x_reg[STAGES] > ONE) ? ONE : (x_reg[STAGES] < -ONE) ? -ONE : x_reg[STAGES];
        yc = (y_reg[STAGES] > ONE) ? ONE : (y_reg[STAGES] < -ONE) ? -ONE : y_reg[STAGES];
        unique case (q_reg[STAGES])
            2'd0:    begin s_next = yc;  c_next = xc;  end
            2'd1:    begin s_next = xc;  c_next = -yc; end
            2'd2:    begin s_next = -yc; c_next = -xc; end
            default: begin s_next = -xc; c_next = yc;  end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sin_reg <= s_next[61:0];
            cos_reg <= c_next[61:0];
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

### hw/rtl/hpb_combine.sv
// ----------------------------------------------------------------------------
// hpb_combine
// Forms the basis vectors: four Q60 magnitude products split into 31- and
// 30-bit limbs, sign and negation, then round half up and saturate to the output.
// ----------------------------------------------------------------------------
module hpb_combine #(
    parameter int OFB = hpb_pkg::DEF_OUT_FRAC_BITS
) (
    input  logic               aclk,
    input  logic               ce,
    input  logic signed [61:0] sa,
    input  logic signed [61:0] ca,
    input  logic signed [61:0] sz,
    input  logic signed [61:0] cz,
    output hpb_pkg::hpb_vec_t  vec_out
);

    localparam int SHO = 60 - OFB;
    localparam logic signed [62:0] HALF = 63'sd1 <<< (SHO - 1);
    localparam logic signed [62:0] LIM  = 63'sd1 <<< OFB;

    // operand order: 0 sin alt, 1 cos alt, 2 sin az, 3 cos az
    logic signed [61:0] raw [0:3];
    logic signed [61:0] raw1_reg [0:3];
    logic signed [61:0] raw2_reg [0:3];
    logic signed [61:0] raw3_reg [0:3];
    logic signed [61:0] raw4_reg [0:3];
    logic [60:0]        mag1_reg [0:3];
    // lanes: ca*sz, ca*cz, sa*sz, sa*cz
    logic [60:0]        la [0:3];
    logic [60:0]        lb [0:3];
    logic               ln [0:3];
    logic [61:0]        pp00_reg [0:3];
    logic [60:0]        pp01_reg [0:3];
    logic [60:0]        pp10_reg [0:3];
    logic [59:0]        pp11_reg [0:3];
    logic               neg2_reg [0:3];
    logic [61:0]        p00_3_reg [0:3];
    logic [61:0]        mid_3_reg [0:3];
    logic [59:0]        p11_3_reg [0:3];
    logic               neg3_reg [0:3];
    logic [120:0]       full [0:3];
    logic [60:0]        mag4_reg [0:3];
    logic               neg4_reg [0:3];
    logic signed [61:0] pm [0:3];
    logic signed [61:0] val5_reg [0:7];
    hpb_pkg::hpb_vec_t  vec_reg, vec_next;

    function automatic logic [31:0] to_out(input logic signed [61:0] v);
        logic signed [62:0] r;
        r = (63'(v) + HALF) >>> SHO;
        if (r > LIM)
            r = LIM;
        if (r < -LIM)
            r = -LIM;
        return r[31:0];
    endfunction

    assign raw[0] = sa;
    assign raw[1] = ca;
    assign raw[2] = sz;
    assign raw[3] = cz;

    always_comb begin
        la[0] = mag1_reg[1]; lb[0] = mag1_reg[2];
        la[1] = mag1_reg[1]; lb[1] = mag1_reg[3];
        la[2] = mag1_reg[0]; lb[2] = mag1_reg[2];
        la[3] = mag1_reg[0]; lb[3] = mag1_reg[3];
        ln[0] = raw1_reg[1][61] ^ raw1_reg[2][61];
        ln[1] = raw1_reg[1][61] ^ raw1_reg[3][61];
        ln[2] = raw1_reg[0][61] ^ raw1_reg[2][61];
        ln[3] = raw1_reg[0][61] ^ raw1_reg[3][61];
        for (int l = 0; l < 4; l++) begin
            // high limb product never reaches bit 59, so the top bit drops
            full[l] = 121'({p11_3_reg[l], 62'd0})
                    + {28'd0, mid_3_reg[l], 31'd0}
                    + {59'd0, p00_3_reg[l]};
            pm[l]   = neg4_reg[l] ? -$signed({1'b0, mag4_reg[l]}) : $signed({1'b0, mag4_reg[l]});
        end
        vec_next.center_x = to_out(val5_reg[0]);
        vec_next.center_y = to_out(val5_reg[1]);
        vec_next.center_z = to_out(val5_reg[2]);
        vec_next.right_x  = to_out(val5_reg[3]);
        vec_next.right_y  = to_out(val5_reg[4]);
        vec_next.up_x     = to_out(val5_reg[5]);
        vec_next.up_y     = to_out(val5_reg[6]);
        vec_next.up_z     = to_out(val5_reg[7]);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 4; k++) begin
                // magnitudes
                raw1_reg[k] <= raw[k];
                mag1_reg[k] <= raw[k][61] ? 61'(-raw[k]) : 61'(raw[k]);
                raw2_reg[k] <= raw1_reg[k];
                raw3_reg[k] <= raw2_reg[k];
                raw4_reg[k] <= raw3_reg[k];
                // limb products
                pp00_reg[k] <= 62'(la[k][30:0]) * 62'(lb[k][30:0]);
                pp01_reg[k] <= 61'(la[k][30:0]) * 61'(lb[k][60:31]);
                pp10_reg[k] <= 61'(la[k][60:31]) * 61'(lb[k][30:0]);
                pp11_reg[k] <= 60'(la[k][60:31]) * 60'(lb[k][60:31]);
                neg2_reg[k] <= ln[k];
                // middle sum
                p00_3_reg[k] <= pp00_reg[k];
                mid_3_reg[k] <= 62'(pp01_reg[k]) + 62'(pp10_reg[k]);
                p11_3_reg[k] <= pp11_reg[k];
                neg3_reg[k]  <= neg2_reg[k];
                // Q60 magnitude, truncated
                mag4_reg[k] <= full[k][120:60];
                neg4_reg[k] <= neg3_reg[k];
            end
            // signed values in output order
            val5_reg[0] <= pm[0];
            val5_reg[1] <= pm[1];
            val5_reg[2] <= raw4_reg[0];
            val5_reg[3] <= -raw4_reg[3];
            val5_reg[4] <= raw4_reg[2];
            val5_reg[5] <= -pm[2];
            val5_reg[6] <= -pm[3];
            val5_reg[7] <= raw4_reg[1];
            vec_reg     <= vec_next;
        end
    end

    assign vec_out = vec_reg;

endmodule

### hw/rtl/hpb_skid.sv
// ----------------------------------------------------------------------------
// hpb_skid
// Output register with a skid stage, so the pipeline moves one more beat
// while a result waits and the ready path is registered.
// ----------------------------------------------------------------------------
module hpb_skid #(
    parameter int DW = hpb_pkg::M_DATA_W + 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_data
);

    logic          out_valid_reg;
    logic [DW-1:0] out_data_reg;
    logic          skid_valid_reg;
    logic [DW-1:0] skid_data_reg;

    assign in_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            // output register free: drain skid first
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
                out_data_reg  <= in_data;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hw/rtl/horizontal_projection_basis_core.sv
// ----------------------------------------------------------------------------
// horizontal_projection_basis_core
// Altitude/azimuth to centre, right and up unit vectors in Q1.OUT_FRAC_BITS.
// ----------------------------------------------------------------------------
// One beat in, one beat out, one beat per clock sustained while m_axis
// takes results. An accepted input beat passes through angle reduction,
// the two parallel CORDIC pipelines, the products and rounding, and then
// the output register; the CORDIC iteration chain is most of that path.
// The whole pipeline advances on one enable taken from the output skid
// stage, so back-pressure holds every beat in place and a stalled result
// never blocks the beat behind it from reaching the skid register.
// m_axis_tuser low marks an altitude beyond +-90 degrees; its vectors are
// all zero.
module horizontal_projection_basis_core #(
    parameter int ANGLE_FRAC_BITS = hpb_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int OUT_FRAC_BITS   = hpb_pkg::DEF_OUT_FRAC_BITS,
    parameter int CORDIC_STAGES   = hpb_pkg::DEF_CORDIC_STAGES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // altitude_deg [24:0], azimuth_deg [50:25], zero pad
    input  logic [hpb_pkg::S_DATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // center_x, center_y, center_z, right_x, right_y, right_z (1 bit),
    // up_x, up_y, up_z from bit 0 up, zero pad
    output logic [hpb_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // basis_valid
    output logic                          m_axis_tuser
);

    localparam int LAT = hpb_pkg::RED_LAT + CORDIC_STAGES + 1 + hpb_pkg::COMB_LAT;
    localparam logic signed [31:0] ALT_LIM = 32'(64'd90 << ANGLE_FRAC_BITS);
    localparam int DW = hpb_pkg::M_DATA_W + 1;

    logic                              ce;
    logic signed [hpb_pkg::ALT_W-1:0]  alt;
    logic signed [hpb_pkg::AZ_W-1:0]   az;
    logic signed [31:0]                alt_ext;
    logic                              alt_ok;
    logic [LAT-1:0]                    vld_reg;
    logic [LAT-1:0]                    ok_reg;
    logic [1:0]                        alt_quad, az_quad;
    logic [63:0]                       alt_z, az_z;
    logic signed [61:0]                sa, ca, sz, cz;
    hpb_pkg::hpb_vec_t                 vec;
    logic [hpb_pkg::M_DATA_W-1:0]      tdata_pre;
    logic [DW-1:0]                     skid_in, skid_out;

    assign alt     = s_axis_tdata[hpb_pkg::ALT_W-1:0];
    assign az      = s_axis_tdata[hpb_pkg::ALT_W +: hpb_pkg::AZ_W];
    assign alt_ext = 32'(alt);
    assign alt_ok  = (alt_ext >= -ALT_LIM) && (alt_ext <= ALT_LIM);

    assign s_axis_tready = ce;

    // beat valid and altitude range flag travel alongside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ok_reg <= {ok_reg[LAT-2:0], alt_ok};
        end
    end

    hpb_reduce #(.W(hpb_pkg::ALT_W), .AFB(ANGLE_FRAC_BITS)) u_red_alt (
        .aclk     (aclk),
        .ce       (ce),
        .angle_in (alt),
        .quad_out (alt_quad),
        .z_out    (alt_z)
    );

    hpb_reduce #(.W(hpb_pkg::AZ_W), .AFB(ANGLE_FRAC_BITS)) u_red_az (
        .aclk     (aclk),
        .ce       (ce),
        .angle_in (az),
        .quad_out (az_quad),
        .z_out    (az_z)
    );

    hpb_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_alt (
        .aclk    (aclk),
        .ce      (ce),
        .quad_in (alt_quad),
        .z_in    (alt_z),
        .sin_out (sa),
        .cos_out (ca)
    );

    hpb_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_az (
        .aclk    (aclk),
        .ce      (ce),
        .quad_in (az_quad),
        .z_in    (az_z),
        .sin_out (sz),
        .cos_out (cz)
    );

    hpb_combine #(.OFB(OUT_FRAC_BITS)) u_combine (
        .aclk    (aclk),
        .ce      (ce),
        .sa      (sa),
        .ca      (ca),
        .sz      (sz),
        .cz      (cz),
        .vec_out (vec)
    );

    // pack the beat; out-of-range altitude gives zero vectors
    always_comb begin
        tdata_pre = {7'd0, vec.up_z, vec.up_y, vec.up_x, 1'b0, vec.right_y, vec.right_x,
                     vec.center_z, vec.center_y, vec.center_x};
        skid_in   = ok_reg[LAT-1] ? {1'b1, tdata_pre} : '0;
    end

    hpb_skid #(.DW(DW)) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld_reg[LAT-1]),
        .in_ready  (ce),
        .in_data   (skid_in),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (skid_out)
    );

    assign m_axis_tdata = skid_out[hpb_pkg::M_DATA_W-1:0];
    assign m_axis_tuser = skid_out[hpb_pkg::M_DATA_W];

endmodule

### hw/rtl/hpb_checker.sv
// ----------------------------------------------------------------------------
// hpb_checker
// Port-level checks on the result stream of the projection basis core.
// ----------------------------------------------------------------------------
module hpb_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [263:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    // a held result beat stays up
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped under back-pressure");

    // no result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result beat after reset");

    // out-of-range altitude gives an all-zero beat
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 264'd0)
        else $error("non-zero vectors on invalid basis");

    // right_z and pad bits are always zero
    a_fixed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !m_axis_tdata[160] && m_axis_tdata[263:257] == 7'd0)
        else $error("fixed bits set");

    // up_z is cos(alt): at most one rounding step below zero for a valid altitude
    a_upz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> $signed(m_axis_tdata[256:225]) >= -32'sd1)
        else $error("negative up_z");

endmodule

bind horizontal_projection_basis_core hpb_checker u_hpb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the horizontal projection basis core. Directions
// are streamed in with random gaps; each result beat is checked field by
// field against an in-bench fixed-point CORDIC predictor of the same maths.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  DEG       = 65536;
    localparam int  ALT_LIM   = 90 * DEG;
    localparam int  STAGES    = 32;
    localparam int  LIMIT     = 400000;
    localparam int  N_FIELDS  = 10;
    localparam logic [63:0] UNIT = 64'd1 << 60;

    // one expected result beat
    typedef struct {
        logic                               vld;
        logic [hpb_pkg::M_DATA_W-1:0]       data;
    } basis_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [hpb_pkg::S_DATA_W-1:0]       s_axis_tdata;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [hpb_pkg::M_DATA_W-1:0]       m_axis_tdata;
    logic                               m_axis_tuser;

    basis_t      basis_q[$];
    int          n_errors;
    int          n_cycles;
    bit          hold_req;
    bit          no_idle;
    logic [63:0] atan_tab[STAGES];
    logic [63:0] inv_gain;
    logic [63:0] rad_lsb;

    horizontal_projection_basis_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock, 12 ns period
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor arithmetic
    // ------------------------------------------------------------------
    function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // arctangent series; x^2 step is a shift, or a division when sq_div != 0
    function automatic logic [63:0] arctan_sum(input logic [63:0] x, input int sq_shift,
                                               input logic [63:0] sq_div);
        logic [63:0] acc;
        logic [63:0] p;
        logic [63:0] k;
        bit          neg;
        acc = 64'd0;
        p   = x;
        k   = 64'd0;
        neg = 1'b0;
        while (p != 64'd0) begin
            acc = neg ? acc - p / (2 * k + 1) : acc + p / (2 * k + 1);
            neg = !neg;
            k   = k + 1;
            if (sq_div != 64'd0)
                p = p / sq_div;
            else if (sq_shift < 64)
                p = p >> sq_shift;
            else
                p = 64'd0;
        end
        return acc;
    endfunction

    task automatic init_trig();
        logic [63:0] qpi;
        logic [63:0] g2;
        logic [63:0] y;
        logic [63:0] t;
        qpi = arctan_sum(UNIT >> 1, 2, 64'd0) + arctan_sum(UNIT / 3, 0, 64'd9);
        atan_tab[0] = qpi;
        for (int i = 1; i < STAGES; i++)
            atan_tab[i] = arctan_sum(UNIT >> i, 2 * i, 64'd0);
        rad_lsb = (4 * qpi + (64'd90 << 16)) / (64'd180 << 16);
        g2 = UNIT;
        for (int i = 0; i < STAGES; i++)
            g2 = g2 + (g2 >> (2 * i));
        y = UNIT / 10 * 6;
        for (int i = 0; i < 8; i++) begin
            t = q60_mul(g2, q60_mul(y, y));
            y = q60_mul(y, 3 * UNIT - t) >> 1;
        end
        inv_gain = y;
    endtask

    function automatic longint unit_clamp(input longint v);
        if (v > longint'(UNIT))
            return longint'(UNIT);
        if (v < -longint'(UNIT))
            return -longint'(UNIT);
        return v;
    endfunction

    // rotation-mode CORDIC after quadrant reduction
    function automatic void sine_cosine(input longint ang, output longint s,
                                        output longint c);
        longint turn;
        longint quarter;
        longint r;
        longint q;
        longint x;
        longint y;
        longint z;
        longint nx;
        turn    = longint'(360) << 16;
        quarter = longint'(90) << 16;
        r = ang % turn;
        if (r < 0)
            r += turn;
        q = r / quarter;
        z = longint'(64'(r - q * quarter) * rad_lsb);
        x = longint'(inv_gain);
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(atan_tab[i]);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(atan_tab[i]);
            end
            x = nx;
        end
        x = unit_clamp(x);
        y = unit_clamp(y);
        case (q & 3)
            0: begin s = y;  c = x;  end
            1: begin s = x;  c = -y; end
            2: begin s = -y; c = -x; end
            default: begin s = -x; c = y; end
        endcase
    endfunction

    function automatic longint signed_mul(input longint a, input longint b);
        logic [63:0] ma;
        logic [63:0] mb;
        longint      m;
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        m  = longint'(q60_mul(ma, mb));
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    // Q60 to Q1.30, round half up, saturate to +-1.0
    function automatic logic [31:0] to_q30(input longint v);
        longint r;
        r = (v + (longint'(1) << 29)) >>> 30;
        if (r > (longint'(1) << 30))
            r = longint'(1) << 30;
        if (r < -(longint'(1) << 30))
            r = -(longint'(1) << 30);
        return r[31:0];
    endfunction

    function automatic basis_t predict_basis(input logic signed [24:0] alt,
                                             input logic signed [25:0] az);
        basis_t b;
        longint sa;
        longint ca;
        longint sz;
        longint cz;
        b.vld  = 1'b0;
        b.data = '0;
        if (int'(alt) < -ALT_LIM || int'(alt) > ALT_LIM)
            return b;
        sine_cosine(longint'(alt), sa, ca);
        sine_cosine(longint'(az), sz, cz);
        b.vld            = 1'b1;
        b.data[31:0]     = to_q30(signed_mul(ca, sz));
        b.data[63:32]    = to_q30(signed_mul(ca, cz));
        b.data[95:64]    = to_q30(sa);
        b.data[127:96]   = to_q30(-cz);
        b.data[159:128]  = to_q30(sz);
        b.data[192:161]  = to_q30(-signed_mul(sa, sz));
        b.data[224:193]  = to_q30(-signed_mul(sa, cz));
        b.data[256:225]  = to_q30(ca);
        return b;
    endfunction

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    task automatic send_direction(input int alt, input int az);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, az[25:0], alt[24:0]};
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        basis_q.push_back(predict_basis(alt[24:0], az[25:0]));
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic int rand_alt();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return $urandom_range(0, 2 * 180 * DEG) - 180 * DEG;
        return $urandom_range(0, 2 * ALT_LIM) - ALT_LIM;
    endfunction

    function automatic int rand_az();
        return $urandom_range(0, 720 * DEG - 1) - 360 * DEG;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        int alts[] = '{0, ALT_LIM, -ALT_LIM, ALT_LIM + 1, -ALT_LIM - 1, 180 * DEG,
                       -180 * DEG, 45 * DEG, -45 * DEG, 1, -1, 30 * DEG};
        int azs[]  = '{0, 90 * DEG, 180 * DEG, 270 * DEG, -90 * DEG, -360 * DEG,
                       360 * DEG - 1, 45 * DEG, 1, -1, -180 * DEG, 720 * DEG};
        foreach (alts[i])
            send_direction(alts[i], azs[i]);
        // azimuth sweep across quadrant edges
        for (int a = -360; a <= 360; a += 90)
            send_direction(10 * DEG, a * DEG);
        go_idle();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 200 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_direction(rand_alt(), rand_az());
        end
        no_idle = 1'b0;
        go_idle();
    endtask

    // long receiver hold while items keep coming: input must stall
    task automatic test_backpressure();
        hold_req = 1'b1;
        no_idle  = 1'b1;
        for (int i = 0; i < 150; i++)
            send_direction(rand_alt(), rand_az());
        no_idle = 1'b0;
        go_idle();
    endtask

    // sender stops until the pipeline has drained completely
    task automatic test_drain_pause();
        while (basis_q.size() != 0)
            @(posedge aclk);
        for (int i = 0; i < 50; i++)
            send_direction(rand_alt(), rand_az());
        go_idle();
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, plus one long hold on request
    // ------------------------------------------------------------------
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid)
                @(posedge aclk);
        end
    end

    // result checker, field by field
    always @(posedge aclk) begin
        basis_t exp_b;
        int     lo;
        int     w;
        logic [31:0] e;
        logic [31:0] a;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (basis_q.size() == 0) begin
                $display("%0t: unexpected result beat tdata=%h", $realtime, m_axis_tdata);
                n_errors++;
            end else begin
                exp_b = basis_q.pop_front();
                if (m_axis_tuser !== exp_b.vld) begin
                    $display("%0t: basis_valid expected %0b actual %0b", $realtime,
                             exp_b.vld, m_axis_tuser);
                    n_errors++;
                end
                // centre x..z, right x, y, z, up x..z, then the pad
                for (int f = 0; f < N_FIELDS; f++) begin
                    lo = (f < 6) ? 32 * f : 161 + 32 * (f - 6);
                    w  = (f == 5) ? 1 : 32;
                    if (f == 9) begin
                        lo = 257;
                        w  = 7;
                    end
                    e = 32'((exp_b.data >> lo) & ((64'd1 << w) - 1));
                    a = 32'((m_axis_tdata >> lo) & ((64'd1 << w) - 1));
                    if (a !== e) begin
                        $display("%0t: field at bit %0d expected %h actual %h", $realtime,
                                 lo, e, a);
                        n_errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int waited;
        n_errors      = 0;
        n_cycles      = 0;
        hold_req      = 1'b0;
        no_idle       = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        init_trig();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(600);
        test_backpressure();
        test_drain_pause();
        test_random(700);

        waited = 0;
        while (basis_q.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (60) @(posedge aclk);
        if (n_errors == 0 && basis_q.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
